>>> hw/rtl/rwkd_pkg.sv
// shared types and constants for the raw word keystream decrypter
`timescale 1ns / 1ps

package rwkd_pkg;

  localparam int WORD_W     = 32;
  localparam int RING_AW    = 7;
  localparam int SEED_WORDS = 4;
  localparam int ADDR_W     = 2;

  localparam logic [WORD_W-1:0]  SEED_MULT    = 32'd48828125;
  localparam logic [RING_AW-1:0] FILL_LAST    = 7'd126;
  localparam logic [RING_AW-1:0] RUN_START    = 7'd127;
  localparam logic [RING_AW-1:0] FEEDBACK_TAP = 7'd65;
  localparam logic [RING_AW-1:0] ADJUST_IDX   = 7'd3;

  localparam logic [ADDR_W-1:0] REG_KEY_SEED = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REKEY,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic [WORD_W-1:0]  data;
  } pad_wr_t;

endpackage

>>> hw/rtl/raw_word_keystream_decrypt_top.sv
// top level: run control, keystream step, output register and config port
// an accepted item passes through the s1 register, then the output register
// throughput: one item per cycle within a run while the output is not stalled
// a run's first item waits for the rekey, which writes one pad word per cycle
// through the ring write port
// reset: run closed, ring position 0, key_seed 0, pad contents undefined
`timescale 1ns / 1ps

module raw_word_keystream_decrypt_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rwkd_pkg::WORD_W-1:0]         in_cipher_word,
  input  logic                                in_last_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rwkd_pkg::WORD_W-1:0]         out_plain_word,
  output logic                                out_last_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rwkd_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  rwkd_pkg::ctrl_state_t state_r, state_nxt;

  logic [rwkd_pkg::WORD_W-1:0]  key_seed_r;
  logic [rwkd_pkg::RING_AW-1:0] ring_pos_r;

  logic                         s1_valid_r;
  logic [rwkd_pkg::WORD_W-1:0]  s1_word_r;
  logic                         s1_last_r;
  logic [rwkd_pkg::RING_AW-1:0] s1_pos_r;

  logic                         out_valid_r;
  logic [rwkd_pkg::WORD_W-1:0]  out_word_r;
  logic                         out_last_r;

  logic                         in_acc;
  logic                         adv;
  logic                         kg_start;
  logic                         kg_done;
  rwkd_pkg::pad_wr_t            kg_wr;
  rwkd_pkg::pad_wr_t            run_wr;
  rwkd_pkg::pad_wr_t            ram_wr;
  logic [rwkd_pkg::WORD_W-1:0]  tap_a;
  logic [rwkd_pkg::WORD_W-1:0]  tap_b;
  logic [rwkd_pkg::WORD_W-1:0]  ks;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == rwkd_pkg::REG_KEY_SEED) ? key_seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_seed_r <= '0;
    end else if (psel && penable && pwrite && (paddr == rwkd_pkg::REG_KEY_SEED)) begin
      key_seed_r <= pwdata;
    end
  end

  // run control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rwkd_pkg::ST_IDLE: begin
        if (in_valid && !s1_valid_r) state_nxt = rwkd_pkg::ST_REKEY;
      end
      rwkd_pkg::ST_REKEY: begin
        if (kg_done) state_nxt = rwkd_pkg::ST_RUN;
      end
      rwkd_pkg::ST_RUN: begin
        if (in_acc && in_last_word) state_nxt = rwkd_pkg::ST_IDLE;
      end
      default: state_nxt = rwkd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    adv      = !out_valid_r || !out_stall;
    // rekey waits until the previous run's last ring write is done
    kg_start = (state_r == rwkd_pkg::ST_IDLE) && in_valid && !s1_valid_r;
    in_stall = (state_r != rwkd_pkg::ST_RUN) || (s1_valid_r && !adv);
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwkd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_pos_r <= '0;
    end else if (kg_done) begin
      ring_pos_r <= rwkd_pkg::RUN_START;
    end else if (in_acc) begin
      ring_pos_r <= ring_pos_r + 7'd1;
    end
  end

  rwkd_keygen u_keygen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kg_start),
    .key   (key_seed_r),
    .wr    (kg_wr),
    .done  (kg_done)
  );

  // keystream step: the write of position p never meets the next item's reads
  assign ks = tap_a ^ tap_b;

  always_comb begin
    run_wr.en   = s1_valid_r && adv;
    run_wr.addr = s1_pos_r;
    run_wr.data = ks;
    ram_wr      = kg_wr.en ? kg_wr : run_wr;
  end

  rwkd_pad_ram u_pad_ram (
    .clk       (clk),
    .wr        (ram_wr),
    .rd_en     (in_acc),
    .rd_addr_a (ring_pos_r + 7'd1),
    .rd_addr_b (ring_pos_r + rwkd_pkg::FEEDBACK_TAP),
    .rd_data_a (tap_a),
    .rd_data_b (tap_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_cipher_word;
      s1_last_r <= in_last_word;
      s1_pos_r  <= ring_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_word_r <= s1_word_r ^ ks;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plain_word = out_word_r;
  assign out_last_out   = out_last_r;

endmodule

>>> hw/rtl/rwkd_pad_ram.sv
// pad ring memory: one write port, two registered read ports
`timescale 1ns / 1ps

module rwkd_pad_ram (
  input  logic                          clk,
  input  rwkd_pkg::pad_wr_t             wr,
  input  logic                          rd_en,
  input  logic [rwkd_pkg::RING_AW-1:0]  rd_addr_a,
  input  logic [rwkd_pkg::RING_AW-1:0]  rd_addr_b,
  output logic [rwkd_pkg::WORD_W-1:0]   rd_data_a,
  output logic [rwkd_pkg::WORD_W-1:0]   rd_data_b
);

  localparam int DEPTH = 1 << rwkd_pkg::RING_AW;

  logic [rwkd_pkg::WORD_W-1:0] mem [DEPTH];
  logic [rwkd_pkg::WORD_W-1:0] rd_a_r;
  logic [rwkd_pkg::WORD_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds while the consumer is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> hw/rtl/rwkd_keygen.sv
// rekey sequencer: seeds four words, then expands the pad one word a cycle
`timescale 1ns / 1ps

module rwkd_keygen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rwkd_pkg::WORD_W-1:0]  key,
  output rwkd_pkg::pad_wr_t            wr,
  output logic                         done
);

  logic                         busy_r;
  logic [rwkd_pkg::RING_AW-1:0] idx_r;
  logic [rwkd_pkg::WORD_W-1:0]  k_r;
  logic [rwkd_pkg::WORD_W-1:0]  win_r [rwkd_pkg::SEED_WORDS];

  logic [rwkd_pkg::WORD_W-1:0]  mul_in;
  logic [rwkd_pkg::WORD_W-1:0]  seed_val;
  logic [rwkd_pkg::WORD_W-1:0]  adj_val;
  logic [rwkd_pkg::WORD_W-1:0]  x02;
  logic [rwkd_pkg::WORD_W-1:0]  x13;
  logic [rwkd_pkg::WORD_W-1:0]  fill_val;
  logic [rwkd_pkg::WORD_W-1:0]  new_val;
  logic                         seeding;

  always_comb begin
    mul_in   = (idx_r == '0) ? key : k_r;
    seed_val = rwkd_pkg::WORD_W'(mul_in * rwkd_pkg::SEED_MULT) + 32'd1;
    x02      = win_r[0] ^ win_r[2];
    x13      = win_r[1] ^ win_r[3];
    // word three: before the shift win_r[1] holds word 0 and win_r[3] word 2
    adj_val  = {seed_val[rwkd_pkg::WORD_W-2:0], x13[rwkd_pkg::WORD_W-1]};
    fill_val = {x02[rwkd_pkg::WORD_W-2:0], x13[rwkd_pkg::WORD_W-1]};
    seeding  = (idx_r < rwkd_pkg::RING_AW'(rwkd_pkg::SEED_WORDS));
    if (seeding) begin
      new_val = (idx_r == rwkd_pkg::ADJUST_IDX) ? adj_val : seed_val;
    end else begin
      new_val = fill_val;
    end
    wr.en   = busy_r;
    wr.addr = idx_r;
    wr.data = new_val;
    done    = busy_r && (idx_r == rwkd_pkg::FILL_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (start && !busy_r) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + 7'd1;
      if (idx_r == rwkd_pkg::FILL_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      k_r      <= seed_val;
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= new_val;
    end
  end

endmodule

>>> tb/tb_raw_word_keystream_decrypt_top.sv
// testbench for the raw word keystream decrypter: predicted plain words checked in order
`timescale 1ns / 1ps

module tb_raw_word_keystream_decrypt_top;
  import rwkd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int PAD_WORDS   = 128;
  localparam int FILL_COUNT  = 127;
  localparam int TAP_OFFSET  = 65;
  localparam logic [31:0] KEY_MULT = 32'd48828125;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } word_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] in_cipher_word = '0;
  logic              in_last_word = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_plain_word;
  logic              out_last_out;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  raw_word_keystream_decrypt_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cipher_word (in_cipher_word),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_plain_word (out_plain_word),
    .out_last_out   (out_last_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // keystream state as the block should hold it
  logic [31:0] key_model = '0;
  logic [31:0] pad_model [PAD_WORDS];
  logic [6:0]  pos_model = '0;
  logic        run_open_model = 1'b0;

  word_item_t cipher_q [$];
  word_item_t plain_q [$];
  int errors = 0;

  function automatic void rekey_pad();
    logic [31:0] k;
    int i;
    k = key_model;
    for (i = 0; i < 4; i++) begin
      k = k * KEY_MULT + 32'd1;
      pad_model[i] = k;
    end
    pad_model[3] = (pad_model[3] << 1) | ((pad_model[0] ^ pad_model[2]) >> 31);
    for (i = 4; i < FILL_COUNT; i++) begin
      pad_model[i] = ((pad_model[i-4] ^ pad_model[i-2]) << 1)
                   | ((pad_model[i-3] ^ pad_model[i-1]) >> 31);
    end
    pos_model = 7'd127;
    run_open_model = 1'b1;
  endfunction

  function automatic void decrypt_word(input logic [31:0] cw, input logic last);
    logic [6:0]  p;
    logic [6:0]  a;
    logic [6:0]  b;
    logic [31:0] ks;
    word_item_t  res;
    if (!run_open_model) rekey_pad();
    p = pos_model;
    a = p + 7'd1;
    b = p + 7'(TAP_OFFSET);
    ks = pad_model[a] ^ pad_model[b];
    pad_model[p] = ks;
    pos_model = p + 7'd1;
    res.word = cw ^ ks;
    res.last = last;
    plain_q.push_back(res);
    if (last) run_open_model = 1'b0;
  endfunction

  // mode 0 never idles, 1 idles lightly, 2 heavily
  function automatic int pick_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 31);
    if (r < ((mode == 1) ? 22 : 12)) return 0;
    if (r < 30) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int drv_gap = 0;
  int drv_mode = 0;
  word_item_t drv_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && !in_stall) decrypt_word(in_cipher_word, in_last_word);
      if ($urandom_range(0, 63) == 0) drv_mode = $urandom_range(0, 2);
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (cipher_q.size() != 0) begin
        drv_item = cipher_q.pop_front();
        in_valid <= 1'b1;
        in_cipher_word <= drv_item.word;
        in_last_word <= drv_item.last;
        drv_gap = pick_gap(drv_mode);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  int rcv_hold = 0;
  int rcv_mode = 0;
  int results_seen = 0;
  bit long_hold_done = 1'b0;
  word_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (plain_q.size() == 0) begin
          $error("result with nothing expected: plain_word %h last_out %b",
                 out_plain_word, out_last_out);
          errors++;
        end else begin
          want = plain_q.pop_front();
          if (out_plain_word !== want.word) begin
            $error("plain_word expected %h actual %h", want.word, out_plain_word);
            errors++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out expected %b actual %b", want.last, out_last_out);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) rcv_mode = $urandom_range(0, 2);
      // one long back-pressure stretch so the block fills and stalls its input
      if (!long_hold_done && results_seen >= 250) begin
        long_hold_done = 1'b1;
        rcv_hold = LONG_HOLD;
      end
      if (rcv_hold > 0) begin
        rcv_hold--;
        out_stall <= 1'b1;
      end else begin
        rcv_hold = pick_gap(rcv_mode);
        out_stall <= (rcv_hold > 0);
        if (rcv_hold > 0) rcv_hold--;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  task automatic add_word(input logic [31:0] w, input logic last);
    word_item_t it;
    it.word = w;
    it.last = last;
    cipher_q.push_back(it);
  endtask

  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic int pick_run_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(129, 300);
    if (r < 4) return 1;
    return $urandom_range(2, 40);
  endfunction

  task automatic queue_run(input int len, input bit close);
    int i;
    for (i = 0; i < len; i++) add_word(rand_word(), close && (i == len - 1));
  endtask

  task automatic drain();
    do @(posedge clk); while (cipher_q.size() != 0 || in_valid || plain_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // write key_seed, then read it back
  task automatic set_key(input logic [31:0] value);
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_KEY_SEED;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_model = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== value) begin
      $error("key_seed readback expected %h actual %h", value, rd);
      errors++;
    end
  endtask

  initial begin
    int ph;
    int n;
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key: one-word run, then a two-word run
    add_word(32'h0000_0000, 1'b1);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b1);
    drain();

    set_key(32'hFFFF_FFFF);
    add_word(32'hAAAA_AAAA, 1'b0);
    add_word(32'h5555_5555, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1);
    add_word(32'h0000_0000, 1'b1);
    drain();

    // key change inside an open run only counts from the next rekey
    add_word(32'h1234_5678, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    drain();
    set_key(32'h0000_0001);
    add_word(32'hFFFF_FFFF, 1'b1);
    add_word(32'h0000_0000, 1'b1);
    drain();

    set_key(32'h8000_0000);
    add_word(32'hDEAD_BEEF, 1'b0);
    add_word(32'h0000_0000, 1'b1);
    drain();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        1: set_key(32'h0000_0000);
        2: set_key(32'hFFFF_FFFF);
        default: set_key($urandom);
      endcase
      n = 0;
      while (n < 200) begin
        len = pick_run_len();
        // the last run of a phase may stay open across the next key write
        queue_run(len, (ph == 4) || (n + len < 200) || ($urandom_range(0, 1) == 1));
        n += len;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (plain_q.size() != 0) begin
      $error("%0d expected results never arrived", plain_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> raw_word_keystream_decrypt_top.f
hw/rtl/rwkd_pkg.sv
hw/rtl/rwkd_pad_ram.sv
hw/rtl/rwkd_keygen.sv
hw/rtl/raw_word_keystream_decrypt_top.sv
tb/tb_raw_word_keystream_decrypt_top.sv
